@@ rtl/core/dmkv_pkg.sv @@
// shared types and constants of the direct-mapped key/value table
package dmkv_pkg;

   localparam int DEPTH_DEFAULT = 1024;

   localparam int OP_W         = 1;
   localparam int KEY_W        = 31;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 3;
   localparam int SLOT_INDEX_W = 10;
   localparam int TABLE_SIZE_W = 11;

   localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = TABLE_SIZE_W'(1024);

   // request kinds
   localparam logic [OP_W-1:0] OP_GET = 1'b0;
   localparam logic [OP_W-1:0] OP_SET = 1'b1;

   // stored value that marks empty data
   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

   // modulo unit: key padded to a whole number of digits, several bits a cycle
   localparam int KEY_PAD_W  = 32;
   localparam int STEP_BITS  = 4;
   localparam int DIV_STEPS  = KEY_PAD_W / STEP_BITS;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GET_HIT   = 3'd0,
      STATUS_GET_EMPTY = 3'd1,
      STATUS_GET_MISS  = 3'd2,
      STATUS_SET_UPD   = 3'd3,
      STATUS_SET_INS   = 3'd4,
      STATUS_SET_DROP  = 3'd5
   } status_type;

   // one slot of the store
   typedef struct packed {
      logic                      valid;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

endpackage

@@ rtl/core/dmkv_front.sv @@
// front end: accepts requests and works out the slot as key modulo table size
module dmkv_front #(
   parameter int DEPTH = dmkv_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic [dmkv_pkg::TABLE_SIZE_W-1:0]   table_size,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dmkv_pkg::OP_W-1:0]           req_op,
   input  logic [dmkv_pkg::KEY_W-1:0]          req_key,
   input  logic signed [dmkv_pkg::VALUE_W-1:0] req_value,
   output logic                                push_valid,
   input  logic                                push_ready,
   output logic [dmkv_pkg::OP_W-1:0]           push_op,
   output logic [dmkv_pkg::KEY_W-1:0]          push_key,
   output logic signed [dmkv_pkg::VALUE_W-1:0] push_value,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] push_slot
);

   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MAX_SIZE = (DEPTH < 2047) ? DEPTH : 2047;
   localparam int DIV_W    = $clog2(MAX_SIZE + 1);

   typedef enum logic [2:0] {
      FS_IDLE = 3'b001,
      FS_DIV  = 3'b010,
      FS_PUSH = 3'b100
   } front_state_type;

   front_state_type                      state_ff, state_in;
   logic [dmkv_pkg::OP_W-1:0]            op_ff;
   logic [dmkv_pkg::KEY_W-1:0]           key_ff;
   logic signed [dmkv_pkg::VALUE_W-1:0]  value_ff;
   logic [dmkv_pkg::KEY_PAD_W-1:0]       shift_ff, shift_in;
   logic [DIV_W-1:0]                     rem_ff, rem_in;
   logic [DIV_W-1:0]                     div_ff;
   logic [dmkv_pkg::STEP_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIV_W-1:0]                     eff_size;
   logic                                 accept;

   // table size saturated into 1..DEPTH
   always_comb begin
      if (table_size == '0) begin
         eff_size = DIV_W'(1);
      end else if (32'(table_size) > 32'(DEPTH)) begin
         eff_size = DIV_W'(DEPTH);
      end else begin
         eff_size = DIV_W'(table_size);
      end
   end

   assign req_ready  = enable && (state_ff == FS_IDLE);
   assign accept     = req_valid && req_ready;
   assign push_valid = (state_ff == FS_PUSH);
   assign push_op    = op_ff;
   assign push_key   = key_ff;
   assign push_value = value_ff;
   assign push_slot  = AW'(rem_ff);

   // restoring remainder, a few bits per cycle
   always_comb begin
      logic [DIV_W:0]                 trial;
      logic [DIV_W-1:0]               rem_v;
      logic [dmkv_pkg::KEY_PAD_W-1:0] sh_v;
      rem_v = rem_ff;
      sh_v  = shift_ff;
      for (int i = 0; i < dmkv_pkg::STEP_BITS; i++) begin
         trial = {rem_v, sh_v[dmkv_pkg::KEY_PAD_W-1]};
         sh_v  = {sh_v[dmkv_pkg::KEY_PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_v = trial[DIV_W-1:0];
      end
      rem_in   = rem_v;
      shift_in = sh_v;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               state_in = FS_DIV;
               cnt_in   = '0;
            end
         end
         FS_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == dmkv_pkg::STEP_CNT_W'(dmkv_pkg::DIV_STEPS - 1)) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (push_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         key_ff   <= req_key;
         value_ff <= req_value;
         shift_ff <= dmkv_pkg::KEY_PAD_W'(req_key);
         rem_ff   <= '0;
         div_ff   <= eff_size;
      end else if (state_ff == FS_DIV) begin
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

@@ rtl/core/dmkv_queue.sv @@
// short queue between front and back
module dmkv_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0]                 slots_ff [dmkv_pkg::QUEUE_DEPTH];
   logic [dmkv_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [dmkv_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [dmkv_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                              do_push, do_pop;

   localparam logic [dmkv_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      dmkv_pkg::QUEUE_PTR_W'(dmkv_pkg::QUEUE_DEPTH - 1);

   assign push_ready = (count_ff != dmkv_pkg::QUEUE_CNT_W'(dmkv_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/dmkv_back.sv @@
// back end: slot store, read-modify-write per request, result register
module dmkv_back #(
   parameter int DEPTH = dmkv_pkg::DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   output logic                                     clear_done,
   input  logic                                     q_valid,
   output logic                                     q_pop,
   input  logic [dmkv_pkg::OP_W-1:0]                q_op,
   input  logic [dmkv_pkg::KEY_W-1:0]               q_key,
   input  logic signed [dmkv_pkg::VALUE_W-1:0]      q_value,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] q_slot,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [dmkv_pkg::STATUS_W-1:0]            rsp_status,
   output logic signed [dmkv_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic [dmkv_pkg::SLOT_INDEX_W-1:0]        rsp_slot_index
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      BS_CLEAR = 3'b001,
      BS_IDLE  = 3'b010,
      BS_EVAL  = 3'b100
   } back_state_type;

   dmkv_pkg::entry_type                  slot_mem [DEPTH];
   dmkv_pkg::entry_type                  rd_data_ff;
   dmkv_pkg::entry_type                  mem_wdata;
   logic [AW-1:0]                        mem_waddr;
   logic                                 mem_we;

   back_state_type                       state_ff, state_in;
   logic [AW-1:0]                        clr_cnt_ff, clr_cnt_in;
   logic [dmkv_pkg::OP_W-1:0]            cur_op_ff;
   logic [dmkv_pkg::KEY_W-1:0]           cur_key_ff;
   logic signed [dmkv_pkg::VALUE_W-1:0]  cur_value_ff;
   logic [AW-1:0]                        cur_slot_ff;

   logic                                 rsp_valid_ff, rsp_valid_in;
   dmkv_pkg::status_type                 rsp_status_ff, status_in;
   logic signed [dmkv_pkg::VALUE_W-1:0]  rsp_read_value_ff, read_value_in;
   logic [AW-1:0]                        rsp_slot_ff;

   logic                                 match;
   logic                                 finish;
   logic                                 set_write;

   assign clear_done = (state_ff != BS_CLEAR);
   assign q_pop      = (state_ff == BS_IDLE) && q_valid;
   assign finish     = (state_ff == BS_EVAL) && (!rsp_valid_ff || rsp_ready);

   // classify against the stored slot
   assign match = rd_data_ff.valid && (rd_data_ff.key == cur_key_ff);

   always_comb begin
      read_value_in = '0;
      set_write     = 1'b0;
      if (cur_op_ff == dmkv_pkg::OP_GET) begin
         if (match) begin
            read_value_in = rd_data_ff.value;
            status_in = (rd_data_ff.value == dmkv_pkg::EMPTY_VALUE) ?
                        dmkv_pkg::STATUS_GET_EMPTY : dmkv_pkg::STATUS_GET_HIT;
         end else begin
            status_in = dmkv_pkg::STATUS_GET_MISS;
         end
      end else begin
         if (match) begin
            status_in = dmkv_pkg::STATUS_SET_UPD;
            set_write = 1'b1;
         end else if (!rd_data_ff.valid) begin
            status_in = dmkv_pkg::STATUS_SET_INS;
            set_write = 1'b1;
         end else begin
            status_in = dmkv_pkg::STATUS_SET_DROP;
         end
      end
   end

   // write port: clearing sweep or the set
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_slot_ff;
      mem_wdata = '{valid: 1'b1, key: cur_key_ff, value: cur_value_ff};
      if (state_ff == BS_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (finish && set_write) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         BS_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: begin
            if (q_valid) begin
               state_in = BS_EVAL;
            end
         end
         BS_EVAL: begin
            if (finish) begin
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (q_pop) begin
         rd_data_ff <= slot_mem[q_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_op_ff    <= q_op;
         cur_key_ff   <= q_key;
         cur_value_ff <= q_value;
         cur_slot_ff  <= q_slot;
      end
      if (finish) begin
         rsp_status_ff     <= status_in;
         rsp_read_value_ff <= read_value_in;
         rsp_slot_ff       <= cur_slot_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_slot_index = dmkv_pkg::SLOT_INDEX_W'(rsp_slot_ff);

endmodule

@@ rtl/core/direct_mapped_key_value_table.sv @@
// top level of the direct-mapped key/value table
//
// requests come in on the req_ channel (valid/ready): req_op picks get or set,
// req_key selects the slot as key modulo the configured table size, and
// req_value is stored on a set. one response beat leaves on the rsp_ channel
// per request, in request order: a status code, the read value (non-zero only
// on a get hit or an empty-data get) and the slot index the key mapped to.
// csr_wr_en/csr_wr_data write the table size; it is saturated into 1..DEPTH
// and takes effect on the next request, stored slots are kept.
// the front end runs the modulo over 4 key bits per cycle and takes a new
// request only from idle (accept, 8 division steps, hand-off to the queue).
// the back end reads the slot into a register on the pop, then classifies
// and writes it back, waiting while a response beat is still unaccepted.
// after reset the slot memory is cleared one slot per cycle, every slot,
// with req_ready held low; csr writes are taken throughout.
// a stalled receiver holds the beat in the response register while the back
// end waits; the queue and then the front end fill and req_ready drops.
module direct_mapped_key_value_table #(
   parameter int DEPTH = dmkv_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [dmkv_pkg::TABLE_SIZE_W-1:0]   csr_wr_data,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dmkv_pkg::OP_W-1:0]           req_op,
   input  logic [dmkv_pkg::KEY_W-1:0]          req_key,
   input  logic signed [dmkv_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dmkv_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [dmkv_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [dmkv_pkg::SLOT_INDEX_W-1:0]   rsp_slot_index
);

   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ITEM_W = dmkv_pkg::OP_W + dmkv_pkg::KEY_W + dmkv_pkg::VALUE_W + AW;

   // table size register
   logic [dmkv_pkg::TABLE_SIZE_W-1:0] table_size_ff, table_size_in;

   assign table_size_in = csr_wr_en ? csr_wr_data : table_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= dmkv_pkg::TABLE_SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   // front end -> queue
   logic                                clear_done;
   logic                                push_valid, push_ready;
   logic [dmkv_pkg::OP_W-1:0]           push_op;
   logic [dmkv_pkg::KEY_W-1:0]          push_key;
   logic signed [dmkv_pkg::VALUE_W-1:0] push_value;
   logic [AW-1:0]                       push_slot;

   // queue -> back end
   logic                                q_valid, q_pop;
   logic [ITEM_W-1:0]                   q_data;
   logic [dmkv_pkg::OP_W-1:0]           q_op;
   logic [dmkv_pkg::KEY_W-1:0]          q_key;
   logic signed [dmkv_pkg::VALUE_W-1:0] q_value;
   logic [AW-1:0]                       q_slot;

   // requests are held off until the clearing sweep has finished
   dmkv_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (clear_done),
      .table_size (table_size_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_key    (req_key),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .push_key   (push_key),
      .push_value (push_value),
      .push_slot  (push_slot)
   );

   dmkv_queue #(
      .DATA_W (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_op, push_key, push_value, push_slot}),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   assign {q_op, q_key, q_value, q_slot} = q_data;

   // slot store and response register
   dmkv_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .clear_done     (clear_done),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_op           (q_op),
      .q_key          (q_key),
      .q_value        (q_value),
      .q_slot         (q_slot),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_slot_index (rsp_slot_index)
   );

   // once the sweep is over it never restarts without a reset
   a_clear_stays_done: assert property (
      @(posedge clock) disable iff (reset) clear_done |=> clear_done
   ) else $error("clearing sweep restarted");

   // no response can exist before the store is cleared
   a_no_rsp_while_clearing: assert property (
      @(posedge clock) disable iff (reset) !clear_done |-> !rsp_valid
   ) else $error("response during clearing sweep");

   // a non-zero read value only comes with a get hit or an empty-data get
   a_read_value_only_on_hit: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_read_value != '0)) |->
         ((rsp_status == dmkv_pkg::STATUS_GET_HIT) ||
          (rsp_status == dmkv_pkg::STATUS_GET_EMPTY))
   ) else $error("read value on a response that is not a get hit");

   // empty-data hit carries the marker value
   a_empty_carries_marker: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == dmkv_pkg::STATUS_GET_EMPTY)) |->
         (rsp_read_value == dmkv_pkg::EMPTY_VALUE)
   ) else $error("empty-data status without marker value");

endmodule
